// ===== src/wbos_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the WSOLA best-start search block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package wbos_pkg;

    // Block sizes.
    localparam int MEM_DEPTH     = 65536;
    localparam int CORR_LEN      = 256;
    localparam int SEARCH_RADIUS = 128;
    localparam int SAMPLE_BITS   = 16;

    // Derived widths.
    localparam int ADDR_W  = $clog2(MEM_DEPTH);
    localparam int CNT_W   = 17;
    localparam int POS_W   = ((ADDR_W > 17) ? ADDR_W : 17) + 2;
    localparam int IDX_W   = $clog2(CORR_LEN);
    localparam int PROD_W  = 2 * SAMPLE_BITS - 1;
    localparam int ENG_W   = PROD_W + IDX_W;
    localparam int DOT_W   = ENG_W + 1;
    localparam int MAG_W   = ENG_W;
    localparam int CMP_W   = 2 * MAG_W + ENG_W;
    localparam int STEP_W  = $clog2(MAG_W + 1);

    // Item kinds and result codes.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [1:0] ST_SEARCHED  = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_TMPL_OOR  = 2'd2;

    // Input and result beats.
    typedef struct packed {
        logic               kind;
        logic [15:0]        sample_address;
        logic signed [15:0] sample_value;
        logic [16:0]        ideal_start;
        logic [16:0]        template_start;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] best_start;
        logic [1:0]  search_status;
    } t_out_beat;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EVAL,
        S_CMP,
        S_DONE
    } t_state;

    // Score comparator states.
    typedef enum logic [1:0] {
        C_IDLE,
        C_SQ,
        C_PR,
        C_DONE
    } t_cmp_state;

    // Request and response of the score comparator.
    typedef struct packed {
        logic                    start;
        logic signed [DOT_W-1:0] dc;
        logic [ENG_W-1:0]        ec;
        logic signed [DOT_W-1:0] db;
        logic [ENG_W-1:0]        eb;
    } t_cmp_req;

    typedef struct packed {
        logic done;
        logic better;
    } t_cmp_rsp;

endpackage

// ===== src/wbos_mem.sv =====
`timescale 1ns / 1ps
// Reference sample memory: one write port and two registered read ports.
// Depends on wbos_pkg for its depth and word width.
module wbos_mem (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [wbos_pkg::ADDR_W-1:0]        i_waddr,
    input  logic [wbos_pkg::SAMPLE_BITS-1:0]   i_wdata,
    input  logic [wbos_pkg::ADDR_W-1:0]        i_raddr_a,
    input  logic [wbos_pkg::ADDR_W-1:0]        i_raddr_b,
    output logic [wbos_pkg::SAMPLE_BITS-1:0]   o_rdata_a,
    output logic [wbos_pkg::SAMPLE_BITS-1:0]   o_rdata_b
);

    logic [wbos_pkg::SAMPLE_BITS-1:0] r_mem [wbos_pkg::MEM_DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== src/wbos_cmp.sv =====
`timescale 1ns / 1ps
// Exact score comparator: decides whether dc/sqrt(ec) beats db/sqrt(eb).
// Uses serial shift-add multipliers; depends on wbos_pkg.
module wbos_cmp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wbos_pkg::t_cmp_req  i_req,
    output wbos_pkg::t_cmp_rsp  o_rsp
);

    wbos_pkg::t_cmp_state r_state, n_state;
    logic [wbos_pkg::STEP_W-1:0] r_step;
    logic                        r_fast;
    logic                        r_fast_val;
    logic                        r_pos;
    logic [wbos_pkg::MAG_W-1:0]  r_ml_l, r_ml_r;
    logic [wbos_pkg::CMP_W-1:0]  r_md_l, r_md_r;
    logic [wbos_pkg::CMP_W-1:0]  r_acc_l, r_acc_r;
    logic [wbos_pkg::ENG_W-1:0]  r_ec, r_eb;

    logic signed [1:0]           w_sc, w_sb;
    logic                        w_zc, w_zb;
    logic                        w_fast;
    logic [wbos_pkg::DOT_W-1:0]  w_negc, w_negb;
    logic [wbos_pkg::MAG_W-1:0]  w_mc, w_mb;
    logic                        w_last_step;

    // Sign of each score; a zero energy or zero dot product scores zero.
    always_comb begin
        w_zc   = (i_req.ec == '0) || (i_req.dc == '0);
        w_zb   = (i_req.eb == '0) || (i_req.db == '0);
        w_sc   = w_zc ? 2'sd0 : (i_req.dc[wbos_pkg::DOT_W-1] ? -2'sd1 : 2'sd1);
        w_sb   = w_zb ? 2'sd0 : (i_req.db[wbos_pkg::DOT_W-1] ? -2'sd1 : 2'sd1);
        w_fast = (w_sc != w_sb) || (w_sc == 2'sd0);
        w_negc = -i_req.dc;
        w_negb = -i_req.db;
        w_mc   = i_req.dc[wbos_pkg::DOT_W-1] ? w_negc[wbos_pkg::MAG_W-1:0]
                                             : i_req.dc[wbos_pkg::MAG_W-1:0];
        w_mb   = i_req.db[wbos_pkg::DOT_W-1] ? w_negb[wbos_pkg::MAG_W-1:0]
                                             : i_req.db[wbos_pkg::MAG_W-1:0];
        w_last_step = (r_step == wbos_pkg::STEP_W'(wbos_pkg::MAG_W - 1));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wbos_pkg::C_IDLE: begin
                if (i_req.start) begin
                    n_state = w_fast ? wbos_pkg::C_DONE : wbos_pkg::C_SQ;
                end
            end
            wbos_pkg::C_SQ: begin
                if (w_last_step) begin
                    n_state = wbos_pkg::C_PR;
                end
            end
            wbos_pkg::C_PR: begin
                if (w_last_step) begin
                    n_state = wbos_pkg::C_DONE;
                end
            end
            wbos_pkg::C_DONE: n_state = wbos_pkg::C_IDLE;
            default: n_state = wbos_pkg::C_IDLE;
        endcase
    end

    // Response: a sign difference or two zero scores decide at once, else the cross products do.
    always_comb begin
        o_rsp.done   = (r_state == wbos_pkg::C_DONE);
        o_rsp.better = r_fast ? r_fast_val
                              : (r_pos ? (r_acc_l > r_acc_r) : (r_acc_l < r_acc_r));
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbos_pkg::C_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == wbos_pkg::C_SQ || r_state == wbos_pkg::C_PR) begin
                r_step <= w_last_step ? '0 : r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // Shift-add datapath: first the squared magnitudes, then times the other energy.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            wbos_pkg::C_IDLE: begin
                if (i_req.start) begin
                    r_fast     <= w_fast;
                    r_fast_val <= (w_sc > w_sb);
                    r_pos      <= (w_sc > 2'sd0);
                    r_ml_l     <= w_mc;
                    r_md_l     <= wbos_pkg::CMP_W'(w_mc);
                    r_ml_r     <= w_mb;
                    r_md_r     <= wbos_pkg::CMP_W'(w_mb);
                    r_ec       <= i_req.ec;
                    r_eb       <= i_req.eb;
                    r_acc_l    <= '0;
                    r_acc_r    <= '0;
                end
            end
            wbos_pkg::C_SQ: begin
                if (w_last_step) begin
                    r_md_l  <= r_ml_l[0] ? r_acc_l + r_md_l : r_acc_l;
                    r_md_r  <= r_ml_r[0] ? r_acc_r + r_md_r : r_acc_r;
                    r_ml_l  <= wbos_pkg::MAG_W'(r_eb);
                    r_ml_r  <= wbos_pkg::MAG_W'(r_ec);
                    r_acc_l <= '0;
                    r_acc_r <= '0;
                end else begin
                    if (r_ml_l[0]) r_acc_l <= r_acc_l + r_md_l;
                    if (r_ml_r[0]) r_acc_r <= r_acc_r + r_md_r;
                    r_md_l <= r_md_l << 1;
                    r_md_r <= r_md_r << 1;
                    r_ml_l <= r_ml_l >> 1;
                    r_ml_r <= r_ml_r >> 1;
                end
            end
            wbos_pkg::C_PR: begin
                if (r_ml_l[0]) r_acc_l <= r_acc_l + r_md_l;
                if (r_ml_r[0]) r_acc_r <= r_acc_r + r_md_r;
                r_md_l <= r_md_l << 1;
                r_md_r <= r_md_r << 1;
                r_ml_l <= r_ml_l >> 1;
                r_ml_r <= r_ml_r >> 1;
            end
            wbos_pkg::C_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/wsola_best_offset_search.sv =====
`timescale 1ns / 1ps
// WSOLA best-start search. A load beat gives no result.
// A search with too short a buffer, a bad template or no candidate answers without a correlation.
// A full search correlates each candidate in turn; from the second on, its score is compared
// with the best so far (at once when the score signs decide), and then the result is loaded.
// Synchronous active-low reset clears control state; the sample memory is not cleared.
module wsola_best_offset_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  wbos_pkg::t_in_beat          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output wbos_pkg::t_out_beat         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [wbos_pkg::CNT_W-1:0]  i_cfg_wdata
);

    localparam int PW = wbos_pkg::POS_W;
    localparam int SB = wbos_pkg::SAMPLE_BITS;

    wbos_pkg::t_state r_state, n_state;

    logic [wbos_pkg::CNT_W-1:0]      r_cfg;
    logic signed [PW-1:0]            r_c, r_c_end, r_tmpl, r_best;
    logic [wbos_pkg::IDX_W-1:0]      r_i;
    logic                            r_rd_vld;
    logic signed [wbos_pkg::DOT_W-1:0] r_acc_d, r_bd;
    logic [wbos_pkg::ENG_W-1:0]      r_acc_e, r_be;
    logic                            r_have;
    logic                            r_out_vld;
    wbos_pkg::t_out_beat             r_out;

    logic signed [PW-1:0] w_n, w_last, w_ideal, w_tmpl, w_clamped, w_lo, w_hi;
    logic                 w_short, w_tmpl_bad, w_none;
    logic                 w_accept, w_out_free;
    logic                 w_mem_we;
    logic [wbos_pkg::ADDR_W-1:0] w_raddr_a, w_raddr_b;
    logic [SB-1:0]        w_rdata_a, w_rdata_b;
    logic signed [2*SB-1:0] w_pd, w_pe;
    logic                 w_step, w_take, w_load_out, w_clear, w_last_i, w_last_c;
    wbos_pkg::t_cmp_req   w_cmp_req;
    wbos_pkg::t_cmp_rsp   w_cmp_rsp;
    wbos_pkg::t_out_beat  w_imm;

    // Search window and special cases, worked out from the incoming beat.
    always_comb begin
        w_n     = (PW'(r_cfg) > PW'(wbos_pkg::MEM_DEPTH)) ? PW'(wbos_pkg::MEM_DEPTH)
                                                        : PW'(r_cfg);
        w_last  = w_n - PW'(wbos_pkg::CORR_LEN);
        w_ideal = PW'(i_in_data.ideal_start);
        w_tmpl  = PW'(i_in_data.template_start);
        w_clamped  = (w_ideal > w_last) ? w_last : w_ideal;
        w_short    = (w_last <= 0);
        w_tmpl_bad = (w_tmpl + PW'(wbos_pkg::CORR_LEN)) > w_n;
        w_lo = w_ideal - PW'(wbos_pkg::SEARCH_RADIUS);
        if (w_lo < 0) w_lo = '0;
        w_hi = w_ideal + PW'(wbos_pkg::SEARCH_RADIUS);
        if (w_hi > w_last) w_hi = w_last;
        w_none = (w_lo > w_hi);
        // Result of a search that needs no correlation.
        priority if (w_short) begin
            w_imm.best_start    = '0;
            w_imm.search_status = wbos_pkg::ST_TOO_SHORT;
        end else if (w_tmpl_bad) begin
            w_imm.best_start    = w_clamped[15:0];
            w_imm.search_status = wbos_pkg::ST_TMPL_OOR;
        end else begin
            w_imm.best_start    = w_clamped[15:0];
            w_imm.search_status = wbos_pkg::ST_SEARCHED;
        end
    end

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_last_i   = (r_i == wbos_pkg::IDX_W'(wbos_pkg::CORR_LEN - 1));
    assign w_last_c   = (r_c == r_c_end);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wbos_pkg::S_IDLE: begin
                if (w_accept && i_in_data.kind == wbos_pkg::KIND_SEARCH
                    && !w_short && !w_tmpl_bad && !w_none) begin
                    n_state = wbos_pkg::S_ISSUE;
                end
            end
            wbos_pkg::S_ISSUE: begin
                if (w_last_i) n_state = wbos_pkg::S_DRAIN;
            end
            wbos_pkg::S_DRAIN: n_state = wbos_pkg::S_EVAL;
            wbos_pkg::S_EVAL: begin
                if (!r_have) begin
                    n_state = w_last_c ? wbos_pkg::S_DONE : wbos_pkg::S_ISSUE;
                end else begin
                    n_state = wbos_pkg::S_CMP;
                end
            end
            wbos_pkg::S_CMP: begin
                if (w_cmp_rsp.done) begin
                    n_state = w_last_c ? wbos_pkg::S_DONE : wbos_pkg::S_ISSUE;
                end
            end
            wbos_pkg::S_DONE: begin
                if (w_out_free) n_state = wbos_pkg::S_IDLE;
            end
            default: n_state = wbos_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != wbos_pkg::S_IDLE)
                     || (i_in_valid && i_in_data.kind == wbos_pkg::KIND_SEARCH && !w_out_free);
        w_accept   = i_in_valid && !o_in_stall;
        w_mem_we   = w_accept && i_in_data.kind == wbos_pkg::KIND_LOAD
                     && (32'(i_in_data.sample_address) < wbos_pkg::MEM_DEPTH);
        w_raddr_a  = wbos_pkg::ADDR_W'(r_c + PW'(r_i));
        w_raddr_b  = wbos_pkg::ADDR_W'(r_tmpl + PW'(r_i));
        w_step     = (r_state == wbos_pkg::S_EVAL && !r_have)
                     || (r_state == wbos_pkg::S_CMP && w_cmp_rsp.done);
        w_take     = (r_state == wbos_pkg::S_EVAL && !r_have)
                     || (r_state == wbos_pkg::S_CMP && w_cmp_rsp.done && w_cmp_rsp.better);
        w_clear    = (r_state == wbos_pkg::S_IDLE) || (w_step && !w_last_c);
        w_load_out = (r_state == wbos_pkg::S_DONE && w_out_free)
                     || (w_accept && i_in_data.kind == wbos_pkg::KIND_SEARCH
                         && (w_short || w_tmpl_bad || w_none));
        w_cmp_req.start = (r_state == wbos_pkg::S_EVAL) && r_have;
        w_cmp_req.dc    = r_acc_d;
        w_cmp_req.ec    = r_acc_e;
        w_cmp_req.db    = r_bd;
        w_cmp_req.eb    = r_be;
    end

    // Products of the current sample pair.
    assign w_pd = $signed(w_rdata_a) * $signed(w_rdata_b);
    assign w_pe = $signed(w_rdata_a) * $signed(w_rdata_a);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wbos_pkg::S_IDLE;
            r_cfg     <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_have    <= 1'b0;
            r_i       <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == wbos_pkg::S_ISSUE);
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == wbos_pkg::S_IDLE) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
            if (r_state == wbos_pkg::S_ISSUE) begin
                r_i <= w_last_i ? '0 : r_i + 1'b1;
            end else begin
                r_i <= '0;
            end
        end
    end

    // Window, accumulators, best-so-far and the result register.
    always_ff @(posedge i_clk) begin
        if (r_state == wbos_pkg::S_IDLE && w_accept) begin
            r_c     <= w_lo;
            r_c_end <= w_hi;
            r_tmpl  <= w_tmpl;
            r_best  <= w_clamped;
        end else if (w_step && !w_last_c) begin
            r_c <= r_c + PW'(1);
        end
        if (w_clear) begin
            r_acc_d <= '0;
            r_acc_e <= '0;
        end else if (r_rd_vld) begin
            r_acc_d <= r_acc_d + wbos_pkg::DOT_W'(w_pd);
            r_acc_e <= r_acc_e + wbos_pkg::ENG_W'(w_pe[wbos_pkg::PROD_W-1:0]);
        end
        if (w_take) begin
            r_bd   <= r_acc_d;
            r_be   <= r_acc_e;
            r_best <= r_c;
        end
        if (w_load_out) begin
            if (r_state == wbos_pkg::S_DONE) begin
                r_out.best_start    <= r_best[15:0];
                r_out.search_status <= wbos_pkg::ST_SEARCHED;
            end else begin
                r_out <= w_imm;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Sample memory; loads only arrive while no search is reading it.
    wbos_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_waddr   (wbos_pkg::ADDR_W'(i_in_data.sample_address)),
        .i_wdata   (SB'(i_in_data.sample_value)),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Serial score comparator.
    wbos_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cmp_req),
        .o_rsp   (w_cmp_rsp)
    );

endmodule

// ===== src/wbos_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the WSOLA best-start search, bound to the top level.
// Depends on wbos_pkg for the beat types and result codes.
module wbos_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input wbos_pkg::t_out_beat o_out_data
);

    // A stalled result beat stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.search_status == wbos_pkg::ST_SEARCHED
                         || o_out_data.search_status == wbos_pkg::ST_TOO_SHORT
                         || o_out_data.search_status == wbos_pkg::ST_TMPL_OOR))
        else $error("undefined search status");

    // A too-short buffer always reports start zero.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.search_status == wbos_pkg::ST_TOO_SHORT
        |-> o_out_data.best_start == '0)
        else $error("short buffer result with nonzero start");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind wsola_best_offset_search wbos_checker u_wbos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== sim/wsola_best_offset_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the WSOLA best-start search block.
// Needs wbos_pkg and wsola_best_offset_search; predicts every result beat and checks it.
module wsola_best_offset_search_test;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    wbos_pkg::t_in_beat            i_in_data;
    logic                          o_out_valid;
    logic                          i_out_stall;
    wbos_pkg::t_out_beat           o_out_data;
    logic                          i_cfg_we;
    logic [wbos_pkg::CNT_W-1:0]    i_cfg_wdata;

    // Sample memory and sample count as the block should hold them.
    logic signed [15:0]  sample_mem [0:wbos_pkg::MEM_DEPTH-1];
    int                  sample_count_cfg;
    wbos_pkg::t_out_beat expected_starts[$];

    int   errors = 0;
    int   searches_sent;
    int   loads_sent;
    int   status_seen[3];
    bit   idle_on;
    bit   hold_req;
    bit   hold_taken;
    int   hold_left;
    int   stall_left;

    wsola_best_offset_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock with a 12 ns period.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // True when score dc/sqrt(ec) beats db/sqrt(eb), compared without a root.
    function automatic bit score_beats(longint dc, longint unsigned ec,
                                       longint db, longint unsigned eb);
        int sc;
        int sb;
        logic [127:0] mc;
        logic [127:0] mb;
        logic [127:0] lhs;
        logic [127:0] rhs;
        sc = (ec == 0 || dc == 0) ? 0 : (dc > 0 ? 1 : -1);
        sb = (eb == 0 || db == 0) ? 0 : (db > 0 ? 1 : -1);
        if (sc != sb) return sc > sb;
        if (sc == 0) return 1'b0;
        mc = (dc < 0) ? 128'(-dc) : 128'(dc);
        mb = (db < 0) ? 128'(-db) : 128'(db);
        lhs = mc * mc * 128'(eb);
        rhs = mb * mb * 128'(ec);
        if (lhs == rhs) return 1'b0;
        return (sc > 0) ? (lhs > rhs) : (lhs < rhs);
    endfunction

    // Best start for one search beat, from the current memory and sample count.
    function automatic wbos_pkg::t_out_beat best_start_for(int ideal, int tmpl);
        wbos_pkg::t_out_beat r;
        int n;
        int last;
        int best;
        int c;
        longint d;
        longint bd;
        longint unsigned e;
        longint unsigned be;
        bit have;
        n = (sample_count_cfg > wbos_pkg::MEM_DEPTH) ? wbos_pkg::MEM_DEPTH : sample_count_cfg;
        last = n - wbos_pkg::CORR_LEN;
        if (last <= 0) begin
            r.best_start = '0;
            r.search_status = wbos_pkg::ST_TOO_SHORT;
            return r;
        end
        best = (ideal > last) ? last : ideal;
        if (tmpl + wbos_pkg::CORR_LEN > n) begin
            r.best_start = best[15:0];
            r.search_status = wbos_pkg::ST_TMPL_OOR;
            return r;
        end
        have = 1'b0;
        bd = 0;
        be = 0;
        for (int off = -wbos_pkg::SEARCH_RADIUS; off <= wbos_pkg::SEARCH_RADIUS; off++) begin
            c = ideal + off;
            if (c < 0 || c > last) continue;
            d = 0;
            e = 0;
            for (int i = 0; i < wbos_pkg::CORR_LEN; i++) begin
                d += longint'(sample_mem[c + i]) * longint'(sample_mem[tmpl + i]);
                e += longint'(sample_mem[c + i]) * longint'(sample_mem[c + i]);
            end
            if (!have || score_beats(d, e, bd, be)) begin
                have = 1'b1;
                bd = d;
                be = e;
                best = c;
            end
        end
        r.best_start = best[15:0];
        r.search_status = wbos_pkg::ST_SEARCHED;
        return r;
    endfunction

    // Result checker: each accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        wbos_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_starts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, actual %0d/%0d", $time,
                         o_out_data.best_start, o_out_data.search_status);
            end else begin
                want = expected_starts.pop_front();
                if (want.best_start !== o_out_data.best_start) begin
                    errors++;
                    $display("%0t: best_start expected %0d actual %0d", $time,
                             want.best_start, o_out_data.best_start);
                end
                if (want.search_status !== o_out_data.search_status) begin
                    errors++;
                    $display("%0t: search_status expected %0d actual %0d", $time,
                             want.search_status, o_out_data.search_status);
                end
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_taken <= 1'b0;
            hold_left <= 0;
            stall_left <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 6) == 0) stall_left <= $urandom_range(1, 15);
        end
    end

    // Offer one beat until accepted, then update the prediction.
    task automatic send_beat(wbos_pkg::t_in_beat b);
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (b.kind == wbos_pkg::KIND_LOAD) begin
            sample_mem[b.sample_address] = b.sample_value;
            loads_sent++;
        end else begin
            expected_starts.push_back(best_start_for(b.ideal_start, b.template_start));
            status_seen[expected_starts[$].search_status]++;
            searches_sent++;
        end
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic send_load(int addr, int value);
        wbos_pkg::t_in_beat b;
        b.kind = wbos_pkg::KIND_LOAD;
        b.sample_address = addr[15:0];
        b.sample_value = value[15:0];
        b.ideal_start = 17'($urandom());
        b.template_start = 17'($urandom());
        send_beat(b);
    endtask

    task automatic send_search(int ideal, int tmpl);
        wbos_pkg::t_in_beat b;
        b.kind = wbos_pkg::KIND_SEARCH;
        b.sample_address = 16'($urandom());
        b.sample_value = 16'($urandom());
        b.ideal_start = ideal[16:0];
        b.template_start = tmpl[16:0];
        send_beat(b);
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_starts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_sample_count(int value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value[wbos_pkg::CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sample_count_cfg = value;
    endtask

    // Sample value for a fill pattern: random, constant, zero, full scale, sparse.
    function automatic int fill_value(int pattern);
        case (pattern)
            0: return $urandom_range(0, 65535);
            1: return 1000;
            2: return 0;
            3: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : 0;
        endcase
    endfunction

    // Set the sample count and fill every entry that a search may read.
    task automatic fill_buffer(int n, int pattern);
        write_sample_count(n);
        for (int a = 0; a < n; a++) send_load(a, fill_value(pattern));
    endtask

    // One random beat within a filled buffer; most searches see few candidates.
    task automatic random_beat(int n);
        int last;
        int sel;
        last = n - wbos_pkg::CORR_LEN;
        sel = $urandom_range(0, 9);
        case (sel)
            0: send_search($urandom_range(0, 131071), $urandom_range(0, 131071));
            1: send_search($urandom_range(0, 131071), $urandom_range(n - 255, 131071));
            2, 3, 4, 5: send_search(last + wbos_pkg::SEARCH_RADIUS - $urandom_range(0, 4),
                                    $urandom_range(0, last));
            6, 7: send_search($urandom_range(0, last), $urandom_range(0, last));
            8: send_search($urandom_range(last + wbos_pkg::SEARCH_RADIUS + 1, 131071),
                           $urandom_range(0, last));
            default: send_load($urandom_range(0, 65535), $urandom_range(0, 65535));
        endcase
    endtask

    // Searches straight after reset and at the extreme sample counts.
    task automatic test_count_extremes();
        send_search(0, 0);
        send_search(131071, 131071);
        write_sample_count(wbos_pkg::CORR_LEN);
        send_search(5, 0);
        write_sample_count(wbos_pkg::MEM_DEPTH);
        send_search(131071, 65281);
        send_search(1000, 131071);
        send_search(131071, 0);
        write_sample_count(131071);
        send_search(70000, 65281);
        send_search(131071, 0);
    endtask

    // Short buffer with full-scale samples: edges of the candidate range.
    task automatic test_candidate_edges();
        fill_buffer(260, 3);
        send_search(0, 0);
        send_search(4, 4);
        send_search(132, 2);
        send_search(133, 1);
        send_search(2, 5);
        send_search(0, 131071);
        send_load(65535, -32768);
        send_load(259, 32767);
        send_search(131, 3);
    endtask

    // Long receiver hold-off fills the block; then the sender waits it out.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) send_search($urandom_range(0, 131071), 131071);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int pats[3] = '{1, 2, 0};
        int n;
        foreach (pats[p]) begin
            n = $urandom_range(257, 290);
            fill_buffer(n, pats[p]);
            for (int k = 0; k < 60; k++) random_beat(n);
        end
    endtask

    // Last stretch at full rate on both sides, over the buffer already loaded.
    task automatic test_full_rate();
        int n;
        wait_drained();
        idle_on = 1'b0;
        n = sample_count_cfg;
        for (int k = 0; k < 50; k++) random_beat(n);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        hold_req = 1'b0;
        idle_on = 1'b1;
        searches_sent = 0;
        loads_sent = 0;
        status_seen = '{0, 0, 0};
        sample_count_cfg = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_count_extremes();
        test_candidate_edges();
        test_backpressure();
        test_random_phases();
        test_full_rate();
        wait_drained();

        $display("Covered %0d sample loads and %0d searches under random stalls.",
                 loads_sent, searches_sent);
        $display("Results by status: searched %0d, too short %0d, template out of range %0d.",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #250_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
